### src/two_level_page_walk_with_swap_assert.svh
// Assertion macros for the two-level page walk block.
// Used by the top level only; needs no package.
`ifndef TWO_LEVEL_PAGE_WALK_WITH_SWAP_ASSERT_SVH
`define TWO_LEVEL_PAGE_WALK_WITH_SWAP_ASSERT_SVH

// same-cycle implication
`define TWPWS_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("twpws assertion failed");

// next-cycle implication
`define TWPWS_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("twpws assertion failed");

`endif

### src/twpws_pkg.sv
// Shared types and constants of the two-level page walk block.
// No dependencies.
package twpws_pkg;

  localparam int ADDR_W  = 12;
  localparam int DATA_W  = 8;
  localparam int FIELD_W = 5;
  localparam int FRAME_W = 7;
  localparam int VA_W    = 15;

  localparam logic [ADDR_W-1:0]  DIR_BASE_RST = 12'hd80;
  localparam logic [FRAME_W-1:0] NO_FRAME     = 7'h7f;

  localparam logic [1:0] MODE_LOAD_MAIN = 2'd0;
  localparam logic [1:0] MODE_LOAD_DISK = 2'd1;
  localparam logic [1:0] MODE_WALK      = 2'd2;
  localparam logic [1:0] MODE_NONE      = 2'd3;

  localparam logic [1:0] ST_MAIN        = 2'd0;
  localparam logic [1:0] ST_DISK        = 2'd1;
  localparam logic [1:0] ST_TABLE_FAULT = 2'd2;
  localparam logic [1:0] ST_PAGE_FAULT  = 2'd3;

  typedef enum logic [1:0] {
    KIND_LOAD_MAIN,
    KIND_LOAD_DISK,
    KIND_WALK
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
    logic [FIELD_W-1:0]  dir_idx;
    logic [FIELD_W-1:0]  tab_idx;
    logic [FIELD_W-1:0]  off;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } bk_stat_t;

endpackage

### src/two_level_page_walk_with_swap.sv
// Top level of the two-level page walk block with swap store.
// Depends on twpws_pkg, twpws_front, twpws_queue, twpws_back and the assert header.
//
//   channel  ports        handshake        beat
//   in       in_*         valid / stall    load or translate command
//   out      out_*        valid / stall    translation result
//   cfg      cfg_*        valid / ready    directory base, 12 bits
//
// A load leaves the back end when popped; a walk holds it for one store read per
// state (directory entry, table entry, data byte) on a registered read port, ending
// early on a fault. The next walk waits until the result is written and the output
// is free. Synchronous reset; stores hold no reset. A stalled output holds back
// only walks; loads ahead drain the queue, and the input stalls when it fills.
`include "two_level_page_walk_with_swap_assert.svh"

module two_level_page_walk_with_swap
  import twpws_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic [ADDR_W-1:0]   in_load_address,
  input  logic [DATA_W-1:0]   in_load_data,
  input  logic [VA_W-1:0]     in_virtual_address,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [FIELD_W-1:0]  out_directory_index,
  output logic                out_directory_valid,
  output logic [FRAME_W-1:0]  out_table_frame,
  output logic [FIELD_W-1:0]  out_table_index,
  output logic                out_entry_valid,
  output logic [FRAME_W-1:0]  out_page_frame,
  output logic [ADDR_W-1:0]   out_physical_address,
  output logic [DATA_W-1:0]   out_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ADDR_W-1:0]   cfg_data
);

  logic [ADDR_W-1:0] dir_base_r;
  logic              push;
  cmd_t              push_cmd;
  cmd_t              q_head;
  q_stat_t           q_stat;
  bk_stat_t          bk_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_base_r <= DIR_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      dir_base_r <= cfg_data;
    end
  end

  twpws_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_load_address    (in_load_address),
    .in_load_data       (in_load_data),
    .in_virtual_address (in_virtual_address),
    .q_stat             (q_stat),
    .push               (push),
    .push_cmd           (push_cmd)
  );

  twpws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (bk_stat.pop),
    .head     (q_head),
    .q_stat   (q_stat)
  );

  twpws_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .dir_base             (dir_base_r),
    .q_head               (q_head),
    .q_stat               (q_stat),
    .bk_stat              (bk_stat),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_directory_index  (out_directory_index),
    .out_directory_valid  (out_directory_valid),
    .out_table_frame      (out_table_frame),
    .out_table_index      (out_table_index),
    .out_entry_valid      (out_entry_valid),
    .out_page_frame       (out_page_frame),
    .out_physical_address (out_physical_address),
    .out_value            (out_value)
  );

  `TWPWS_ASSERT_NOW(a_push_not_full, clk, rst_n, push, !q_stat.full)
  `TWPWS_ASSERT_NOW(a_pop_not_empty, clk, rst_n, bk_stat.pop, !q_stat.empty)
  `TWPWS_ASSERT_NEXT(a_result_from_walk, clk, rst_n, !out_valid && !bk_stat.busy, !out_valid)
  `TWPWS_ASSERT_NOW(a_fault_zero_value, clk, rst_n, out_valid && (out_status == ST_TABLE_FAULT || out_status == ST_PAGE_FAULT), (out_value == '0) && !out_entry_valid)

endmodule

### src/twpws_front.sv
// Front end: input register, mode decode and virtual address split.
// Depends on twpws_pkg.
module twpws_front
  import twpws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_mode,
  input  logic [ADDR_W-1:0]    in_load_address,
  input  logic [DATA_W-1:0]    in_load_data,
  input  logic [VA_W-1:0]      in_virtual_address,
  input  q_stat_t              q_stat,
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic fr_valid_r, fr_valid_nxt;
  cmd_t fr_cmd_r, fr_cmd_nxt;
  logic take;
  logic keep;

  assign in_stall = fr_valid_r && q_stat.full;
  assign push     = fr_valid_r && !q_stat.full;
  assign push_cmd = fr_cmd_r;
  assign take     = in_valid && !in_stall;

  always_comb begin
    keep             = 1'b1;
    fr_cmd_nxt       = fr_cmd_r;
    fr_cmd_nxt.addr  = in_load_address;
    fr_cmd_nxt.data  = in_load_data;
    fr_cmd_nxt.dir_idx = in_virtual_address[3*FIELD_W-1:2*FIELD_W];
    fr_cmd_nxt.tab_idx = in_virtual_address[2*FIELD_W-1:FIELD_W];
    fr_cmd_nxt.off     = in_virtual_address[FIELD_W-1:0];
    unique case (in_mode)
      MODE_LOAD_MAIN: fr_cmd_nxt.kind = KIND_LOAD_MAIN;
      MODE_LOAD_DISK: fr_cmd_nxt.kind = KIND_LOAD_DISK;
      MODE_WALK:      fr_cmd_nxt.kind = KIND_WALK;
      MODE_NONE: begin
        fr_cmd_nxt.kind = KIND_WALK;
        keep            = 1'b0;
      end
    endcase
    if (take) begin
      fr_valid_nxt = keep;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end else begin
      fr_valid_nxt = fr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_cmd_r <= fr_cmd_nxt;
    end
  end

endmodule

### src/twpws_queue.sv
// Command queue between front and back end.
// Depends on twpws_pkg.
module twpws_queue
  import twpws_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t            ent_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);
  assign head         = ent_r[rp_r];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == LAST) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == LAST) ? '0 : rp_r + PW'(1);
    end
    priority if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

### src/twpws_back.sv
// Back end: main and disk stores, walk sequencer and result register.
// Depends on twpws_pkg.
module twpws_back
  import twpws_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [ADDR_W-1:0]   dir_base,
  input  cmd_t                q_head,
  input  q_stat_t             q_stat,
  output bk_stat_t            bk_stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [FIELD_W-1:0]  out_directory_index,
  output logic                out_directory_valid,
  output logic [FRAME_W-1:0]  out_table_frame,
  output logic [FIELD_W-1:0]  out_table_index,
  output logic                out_entry_valid,
  output logic [FRAME_W-1:0]  out_page_frame,
  output logic [ADDR_W-1:0]   out_physical_address,
  output logic [DATA_W-1:0]   out_value
);

  localparam int DEPTH = 1 << ADDR_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIR  = 2'd1;
  localparam logic [1:0] S_TAB  = 2'd2;
  localparam logic [1:0] S_DATA = 2'd3;

  typedef struct packed {
    logic [1:0]          status;
    logic [FIELD_W-1:0]  dir_idx;
    logic                dir_valid;
    logic [FRAME_W-1:0]  tab_frame;
    logic [FIELD_W-1:0]  tab_idx;
    logic                ent_valid;
    logic [FRAME_W-1:0]  page_frame;
    logic [ADDR_W-1:0]   phys;
    logic [DATA_W-1:0]   value;
  } res_t;

  logic [DATA_W-1:0] main_mem [DEPTH];
  logic [DATA_W-1:0] disk_mem [DEPTH];
  logic [DATA_W-1:0] main_rd_r, disk_rd_r;
  logic [ADDR_W-1:0] main_raddr, disk_raddr;
  logic              main_we, disk_we;

  logic [1:0]         st_r, st_nxt;
  logic [FIELD_W-1:0] dir_idx_r, tab_idx_r, off_r;
  logic               dir_valid_r, ent_valid_r;
  logic [FRAME_W-1:0] tab_frame_r, page_frame_r;
  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res_nxt;

  logic [DATA_W-1:0]  pte;
  logic               tfault, pfault;
  logic               free, out_wr, out_free, pop;
  logic               lat_dir, lat_tab, lat_walk;

  assign tfault   = !main_rd_r[DATA_W-1] && (main_rd_r[FRAME_W-1:0] == NO_FRAME);
  assign pte      = dir_valid_r ? main_rd_r : disk_rd_r;
  assign pfault   = !pte[DATA_W-1] && (pte[FRAME_W-1:0] == NO_FRAME);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    st_nxt     = st_r;
    free       = 1'b0;
    out_wr     = 1'b0;
    lat_dir    = 1'b0;
    lat_tab    = 1'b0;
    lat_walk   = 1'b0;
    main_we    = 1'b0;
    disk_we    = 1'b0;
    main_raddr = {tab_frame_r, tab_idx_r};
    disk_raddr = {tab_frame_r, tab_idx_r};
    res_nxt    = res_r;
    res_nxt.dir_idx    = dir_idx_r;
    res_nxt.tab_idx    = tab_idx_r;
    res_nxt.dir_valid  = dir_valid_r;
    res_nxt.tab_frame  = tab_frame_r;
    res_nxt.ent_valid  = ent_valid_r;
    res_nxt.page_frame = page_frame_r;
    res_nxt.phys       = {page_frame_r, off_r};
    res_nxt.value      = '0;
    res_nxt.status     = ST_MAIN;
    unique case (st_r)
      S_IDLE: begin
        free = 1'b1;
      end
      S_DIR: begin
        lat_dir    = 1'b1;
        main_raddr = {main_rd_r[FRAME_W-1:0], tab_idx_r};
        disk_raddr = {main_rd_r[FRAME_W-1:0], tab_idx_r};
        if (tfault) begin
          out_wr             = 1'b1;
          free               = 1'b1;
          st_nxt             = S_IDLE;
          res_nxt.status     = ST_TABLE_FAULT;
          res_nxt.dir_valid  = 1'b0;
          res_nxt.tab_frame  = main_rd_r[FRAME_W-1:0];
          res_nxt.ent_valid  = 1'b0;
          res_nxt.page_frame = '0;
          res_nxt.phys       = '0;
        end else begin
          st_nxt = S_TAB;
        end
      end
      S_TAB: begin
        lat_tab    = 1'b1;
        main_raddr = {pte[FRAME_W-1:0], off_r};
        disk_raddr = {pte[FRAME_W-1:0], off_r};
        if (pfault) begin
          out_wr             = 1'b1;
          free               = 1'b1;
          st_nxt             = S_IDLE;
          res_nxt.status     = ST_PAGE_FAULT;
          res_nxt.ent_valid  = 1'b0;
          res_nxt.page_frame = pte[FRAME_W-1:0];
          res_nxt.phys       = {pte[FRAME_W-1:0], off_r};
        end else begin
          st_nxt = S_DATA;
        end
      end
      S_DATA: begin
        out_wr         = 1'b1;
        free           = 1'b1;
        st_nxt         = S_IDLE;
        res_nxt.status = ent_valid_r ? ST_MAIN : ST_DISK;
        res_nxt.value  = ent_valid_r ? main_rd_r : disk_rd_r;
      end
    endcase

    pop = free && !q_stat.empty &&
          ((q_head.kind != KIND_WALK) || (!out_wr && out_free));
    if (pop) begin
      unique case (q_head.kind)
        KIND_LOAD_MAIN: main_we = 1'b1;
        KIND_LOAD_DISK: disk_we = 1'b1;
        KIND_WALK: begin
          lat_walk   = 1'b1;
          main_raddr = dir_base + {{(ADDR_W-FIELD_W){1'b0}}, q_head.dir_idx};
          st_nxt     = S_DIR;
        end
        default: ;
      endcase
    end

    if (out_wr) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lat_walk) begin
      dir_idx_r <= q_head.dir_idx;
      tab_idx_r <= q_head.tab_idx;
      off_r     <= q_head.off;
    end
    if (lat_dir) begin
      dir_valid_r <= main_rd_r[DATA_W-1];
      tab_frame_r <= main_rd_r[FRAME_W-1:0];
    end
    if (lat_tab) begin
      ent_valid_r  <= pte[DATA_W-1];
      page_frame_r <= pte[FRAME_W-1:0];
    end
    if (out_wr) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[q_head.addr] <= q_head.data;
    end
    main_rd_r <= main_mem[main_raddr];
  end

  always_ff @(posedge clk) begin
    if (disk_we) begin
      disk_mem[q_head.addr] <= q_head.data;
    end
    disk_rd_r <= disk_mem[disk_raddr];
  end

  assign bk_stat.pop  = pop;
  assign bk_stat.busy = (st_r != S_IDLE);

  assign out_valid            = out_valid_r;
  assign out_status           = res_r.status;
  assign out_directory_index  = res_r.dir_idx;
  assign out_directory_valid  = res_r.dir_valid;
  assign out_table_frame      = res_r.tab_frame;
  assign out_table_index      = res_r.tab_idx;
  assign out_entry_valid      = res_r.ent_valid;
  assign out_page_frame       = res_r.page_frame;
  assign out_physical_address = res_r.phys;
  assign out_value            = res_r.value;

endmodule
